>>> design/ffba_pkg.sv
// ============================================================================
// ffba_pkg: shared types and constants for the first-fit block allocator
// Transaction payloads, status codes, table entry layout and FSM states.
// ============================================================================
package ffba_pkg;

    // Heap offsets are this wide; the field widths of both channels follow it
    localparam int ADDR_BITS        = 20;
    localparam int LIMIT_W          = ADDR_BITS + 1;
    localparam int MAX_BLOCKS_DEF   = 64;
    localparam int HEADER_BYTES_DEF = 16;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1) << ADDR_BITS;

    typedef enum logic [0:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_IGNORED = 2'd1,
        ST_NOMEM   = 2'd2,
        ST_UNKNOWN = 2'd3
    } t_status;

    typedef struct packed {
        t_op                  opcode;
        logic [ADDR_BITS-1:0] request_size;
        logic [ADDR_BITS-1:0] payload_address;
    } t_in_item;

    typedef struct packed {
        t_status              status;
        logic [ADDR_BITS-1:0] result_address;
        logic                 block_reused;
    } t_out_item;

    // One row of the block table
    typedef struct packed {
        logic [ADDR_BITS-1:0] start;
        logic [ADDR_BITS-1:0] length;
        logic                 free;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_DONE = 2'd2
    } t_state;

endpackage

>>> design/ffba_ram.sv
// ============================================================================
// ffba_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one read per cycle; read data is registered.
// ============================================================================
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/ffba_engine.sv
// ============================================================================
// ffba_engine: block table scan and update
// Walks the block table one entry per cycle, applies first-fit reuse,
// append at the break, mark-free or tail removal, and holds the result.
// ============================================================================
module ffba_engine
    import ffba_pkg::*;
#(
    parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  t_in_item           i_in_data,
    output logic               o_busy,
    input  logic [LIMIT_W-1:0] i_heap_limit,
    output logic               o_res_valid,
    output t_out_item          o_res,
    input  logic               i_res_ready
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int SUM_W = ADDR_BITS + 2;

    localparam logic [SUM_W-1:0]   HDR_S   = SUM_W'(HEADER_BYTES);
    localparam logic [LIMIT_W-1:0] CAP     = LIMIT_W'(1) << ADDR_BITS;
    localparam logic [CNT_W-1:0]   CNT_MAX = CNT_W'(MAX_BLOCKS);

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [LIMIT_W-1:0]   r_break, n_break;
    logic [CNT_W-1:0]     r_rd_idx, n_rd_idx;
    logic                 r_chk_valid, n_chk_valid;
    logic [IDX_W-1:0]     r_chk_idx, n_chk_idx;
    t_op                  r_op, n_op;
    logic [ADDR_BITS-1:0] r_size, n_size;
    logic [ADDR_BITS-1:0] r_addr, n_addr;
    t_out_item            r_res, n_res;

    logic                 rd_en;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    t_entry               wr_data;
    logic [ENTRY_W-1:0]   rd_raw;
    t_entry               rd_entry;

    logic [LIMIT_W-1:0]   eff_limit;
    logic [SUM_W-1:0]     append_end;
    logic [SUM_W-1:0]     brk_hdr;
    logic [SUM_W-1:0]     start_hdr;
    logic [SUM_W-1:0]     blk_end;
    logic                 alloc_hit;
    logic                 free_hit;
    logic                 hit;
    logic                 is_tail;
    logic                 append_ok;

    // Block table storage
    ffba_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_idx[IDX_W-1:0]),
        .o_rd_data (rd_raw)
    );

    assign rd_entry = t_entry'(rd_raw);

    // Match logic on the entry read last cycle
    assign start_hdr = SUM_W'(rd_entry.start) + HDR_S;
    assign blk_end   = SUM_W'(r_addr) + SUM_W'(rd_entry.length);
    assign alloc_hit = rd_entry.free && (rd_entry.length >= r_size);
    assign free_hit  = (start_hdr == SUM_W'(r_addr));
    assign hit       = r_chk_valid && ((r_op == OP_ALLOC) ? alloc_hit : free_hit);
    assign is_tail   = (blk_end == SUM_W'(r_break))
                    && ((CNT_W'(r_chk_idx) + CNT_W'(1)) == r_count);

    // Append check against the clamped limit
    assign eff_limit  = (i_heap_limit > CAP) ? CAP : i_heap_limit;
    assign append_end = SUM_W'(r_break) + HDR_S + SUM_W'(r_size);
    assign brk_hdr    = SUM_W'(r_break) + HDR_S;
    assign append_ok  = (r_count != CNT_MAX) && (append_end <= SUM_W'(eff_limit));

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_break     <= '0;
            r_chk_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_break     <= n_break;
            r_chk_valid <= n_chk_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rd_idx  <= n_rd_idx;
        r_chk_idx <= n_chk_idx;
        r_op      <= n_op;
        r_size    <= n_size;
        r_addr    <= n_addr;
        r_res     <= n_res;
    end

    // Next state, scan control and table updates
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_break     = r_break;
        n_rd_idx    = r_rd_idx;
        n_chk_valid = r_chk_valid;
        n_chk_idx   = r_chk_idx;
        n_op        = r_op;
        n_size      = r_size;
        n_addr      = r_addr;
        n_res       = r_res;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = r_chk_idx;
        wr_data     = rd_entry;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op        = i_in_data.opcode;
                    n_size      = i_in_data.request_size;
                    n_addr      = i_in_data.payload_address;
                    n_rd_idx    = '0;
                    n_chk_valid = 1'b0;
                    // zero size or null free: nothing to look up
                    if ((i_in_data.opcode == OP_ALLOC && i_in_data.request_size == '0) ||
                        (i_in_data.opcode == OP_FREE && i_in_data.payload_address == '0)) begin
                        n_res   = '{status: ST_IGNORED, result_address: '0, block_reused: 1'b0};
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                // issue next read while checking the previous one
                rd_en       = (r_rd_idx != r_count);
                n_chk_valid = rd_en;
                n_chk_idx   = r_rd_idx[IDX_W-1:0];
                if (rd_en) begin
                    n_rd_idx = r_rd_idx + CNT_W'(1);
                end

                if (hit) begin
                    n_chk_valid = 1'b0;
                    n_state     = S_DONE;
                    if (r_op == OP_ALLOC) begin
                        wr_en        = 1'b1;
                        wr_data.free = 1'b0;
                        n_res = '{status: ST_DONE,
                                  result_address: start_hdr[ADDR_BITS-1:0],
                                  block_reused: 1'b1};
                    end else begin
                        if (is_tail) begin
                            // last block ends at the break: drop it
                            n_break = LIMIT_W'(rd_entry.start);
                            n_count = r_count - CNT_W'(1);
                        end else begin
                            wr_en        = 1'b1;
                            wr_data.free = 1'b1;
                        end
                        n_res = '{status: ST_DONE, result_address: '0, block_reused: 1'b0};
                    end
                end else if (r_rd_idx == r_count) begin
                    // table exhausted without a match
                    n_chk_valid = 1'b0;
                    n_state     = S_DONE;
                    if (r_op == OP_ALLOC) begin
                        if (append_ok) begin
                            wr_en   = 1'b1;
                            wr_addr = r_count[IDX_W-1:0];
                            wr_data = '{start: r_break[ADDR_BITS-1:0],
                                        length: r_size, free: 1'b0};
                            n_count = r_count + CNT_W'(1);
                            n_break = append_end[LIMIT_W-1:0];
                            n_res   = '{status: ST_DONE,
                                        result_address: brk_hdr[ADDR_BITS-1:0],
                                        block_reused: 1'b0};
                        end else begin
                            n_res = '{status: ST_NOMEM, result_address: '0,
                                      block_reused: 1'b0};
                        end
                    end else begin
                        n_res = '{status: ST_UNKNOWN, result_address: '0, block_reused: 1'b0};
                    end
                end
            end

            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

    // Block count stays within the table
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("block count exceeds table depth");

    // Read pointer never runs past the live entries
    a_rd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_rd_idx <= r_count))
        else $error("scan read pointer past block count");

    // Table writes only finish a scan
    a_wr_ends_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> (r_state == S_DONE))
        else $error("table write outside scan completion");

    // Count moves only at the end of a scan
    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(r_state) != S_SCAN) |-> $stable(r_count))
        else $error("block count changed outside scan");

    // Break moves only together with the count
    a_break_with_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_break)) |-> !$stable(r_count))
        else $error("heap break changed without block count");

endmodule

>>> design/first_fit_block_allocator.sv
// ============================================================================
// first_fit_block_allocator: first-fit heap allocator top level
// Heap limit register, table engine and registered result output.
// ============================================================================
//
//  channel  direction  handshake                 payload
//  -------  ---------  ------------------------  ----------------------------
//  in       input      i_in_valid / o_in_stall   i_in_data  (t_in_item)
//  out      output     o_out_valid / i_out_stall o_out_data (t_out_item)
//  cfg      input      i_cfg_valid / o_cfg_ready i_cfg_data (heap_limit)
//
//  An allocate or free scans the block table one entry per cycle through
//  the table RAM's read port, checking up to block count (at most
//  MAX_BLOCKS) entries before its result moves to the output register.
//  Zero-size and null requests skip the scan. One transaction is in work at
//  a time; the next is accepted once the result moves to the output register.
//  Synchronous active-low reset empties the table and sets the limit to 2^20.
//  A held result stalls the engine until the output register frees up.
//
module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [LIMIT_W-1:0] i_cfg_data
);

    logic [LIMIT_W-1:0] r_limit;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out_data;
    logic               busy;
    logic               res_valid;
    t_out_item          res;
    logic               res_ready;

    // Table engine
    ffba_engine #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .o_busy       (busy),
        .i_heap_limit (r_limit),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .i_res_ready  (res_ready)
    );

    assign o_in_stall  = busy;
    assign o_cfg_ready = 1'b1;

    // Heap limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_data;
        end
    end

    // Output register: loads when empty or being drained
    assign res_ready = !r_out_valid || !i_out_stall;

    always_comb begin
        n_out_valid = r_out_valid;
        if (res_ready) begin
            n_out_valid = res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
